// ----- hw/rtl/cwre_pkg.sv -----
// Shared types, constants and helpers for the congestion window / RTO estimator.
// Used by every module of the block; no dependencies.
package cwre_pkg;

  // Field widths
  localparam int unsigned CmdW   = 1;
  localparam int unsigned RttW   = 16;
  localparam int unsigned WinW   = 24;
  localparam int unsigned RtoW   = 13;
  localparam int unsigned LimW   = 16;
  localparam int unsigned EstW   = 20;  // scaled mean / deviation stay below 2^19
  localparam int unsigned SumW   = EstW + 1;
  localparam int unsigned GrowW  = WinW + 1;

  // Stream payload widths (tdata padded to whole bytes)
  localparam int unsigned InDataW  = 40;  // rtt_ms, receiver_window
  localparam int unsigned InUserW  = 2;   // cmd, sample_valid
  localparam int unsigned OutDataW = 80;  // timeout, send_limit, cwnd, ssthresh + pad

  // Constants
  localparam logic [RtoW-1:0] RtoMax   = RtoW'(5000);
  localparam logic [RtoW-1:0] RtoMin   = RtoW'(500);
  localparam logic [SumW-1:0] RtoGuard = SumW'(10);
  localparam logic [WinW-1:0] FxOne    = WinW'(256);
  localparam logic [WinW-1:0] FxTwo    = WinW'(512);
  localparam logic [WinW-1:0] InitWindowRst = WinW'(512);
  localparam logic [WinW-1:0] WindowCapRst  = WinW'(16384);

  // Event kinds
  typedef enum logic [CmdW-1:0] {
    CMD_ACK     = 1'b0,
    CMD_TIMEOUT = 1'b1
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_INITIAL_WINDOW = 1'b0,
    REG_WINDOW_CAP     = 1'b1
  } reg_idx_t;

  // One input item
  typedef struct packed {
    cmd_t              cmd;
    logic              sample_valid;
    logic [RttW-1:0]   rtt_ms;
    logic [WinW-1:0]   receiver_window;
  } item_t;

  // Controller state
  typedef struct packed {
    logic              have_sample;
    logic [EstW-1:0]   scaled_mean;
    logic [EstW-1:0]   scaled_deviation;
    logic [RtoW-1:0]   rto_value;
    logic [WinW-1:0]   window_now;
    logic [WinW-1:0]   threshold_now;
    logic [WinW-1:0]   peer_window;
  } state_t;

  // One result item
  typedef struct packed {
    logic [RtoW-1:0]   timeout_ms;
    logic [LimW-1:0]   send_limit;
    logic [WinW-1:0]   cong_window;
    logic [WinW-1:0]   slow_start_limit;
  } result_t;

  // Clamp a timeout candidate to RtoMin..RtoMax
  function automatic logic [RtoW-1:0] clamp_rto(input logic [SumW-1:0] v);
    logic [RtoW-1:0] r;
    if (v > SumW'(RtoMax)) begin
      r = RtoMax;
    end else if (v < SumW'(RtoMin)) begin
      r = RtoMin;
    end else begin
      r = v[RtoW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/cwre_in_stage.sv -----
// Input register stage: captures one event item and holds it until the
// update stage takes it. Depends on cwre_pkg.
module cwre_in_stage import cwre_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   s_tvalid,
  output logic   s_tready,
  input  item_t  s_item,
  output logic   item_valid,
  output item_t  item,
  input  logic   take
);

  // Free when empty or when the held item leaves this cycle
  assign s_tready = !item_valid || take;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_item;
    end
  end

endmodule

// ----- hw/rtl/cwre_update.sv -----
// Next-state logic: Jacobson/Karels estimator, slow start / additive growth
// and timeout backoff for one event. Purely combinational. Depends on cwre_pkg.
module cwre_update import cwre_pkg::*; (
  input  item_t            item,
  input  state_t           cur,
  input  logic [WinW-1:0]  window_cap,
  output state_t           nxt,
  output result_t          res
);

  logic signed [EstW-2:0]  err;        // m - mean, 19 bits signed
  logic [EstW-2:0]         mag;
  logic [SumW-1:0]         mean_sum;
  logic [SumW-1:0]         dev_sum;
  logic [EstW-1:0]         mean_new;
  logic [EstW-1:0]         dev_new;
  logic [SumW-1:0]         rto_seed;
  logic [SumW-1:0]         rto_est;
  logic [SumW-1:0]         rto_back;
  logic [GrowW-1:0]        grow;
  logic [WinW-1:0]         grown;
  logic [WinW-1:0]         half;
  logic [WinW-1:0]         lim;

  // Estimator update
  always_comb begin
    err      = $signed({3'b000, item.rtt_ms}) - $signed({2'b00, cur.scaled_mean[EstW-1:3]});
    mag      = err[EstW-2] ? (EstW-1)'(-err) : (EstW-1)'(err);
    mean_sum = SumW'(cur.scaled_mean) + SumW'(err);
    mean_new = mean_sum[EstW-1:0];
    dev_sum  = SumW'(cur.scaled_deviation) - SumW'(cur.scaled_deviation[EstW-1:2])
               + SumW'(mag);
    dev_new  = dev_sum[EstW-1:0];
    rto_seed = SumW'({item.rtt_ms, 2'b00}) + RtoGuard;
    rto_est  = SumW'(mean_new[EstW-1:3]) + SumW'(dev_new) + RtoGuard;
    rto_back = SumW'({cur.rto_value, 1'b0});
  end

  // Window growth and timeout halving
  always_comb begin
    if (cur.window_now < cur.threshold_now) begin
      grow = {cur.window_now, 1'b0};
    end else begin
      grow = GrowW'(cur.window_now) + GrowW'(FxOne);
    end
    grown = (grow > GrowW'(window_cap)) ? window_cap : grow[WinW-1:0];
    half  = cur.window_now >> 1;
  end

  // Select by event kind
  always_comb begin
    nxt = cur;
    unique case (item.cmd)
      CMD_ACK: begin
        nxt.peer_window = item.receiver_window;
        if (item.sample_valid) begin
          nxt.have_sample = 1'b1;
          nxt.window_now  = grown;
          if (!cur.have_sample) begin
            nxt.scaled_mean      = EstW'({item.rtt_ms, 3'b000});
            nxt.scaled_deviation = '0;
            nxt.rto_value        = clamp_rto(rto_seed);
          end else begin
            nxt.scaled_mean      = mean_new;
            nxt.scaled_deviation = dev_new;
            nxt.rto_value        = clamp_rto(rto_est);
          end
        end
      end
      CMD_TIMEOUT: begin
        nxt.rto_value     = clamp_rto(rto_back);
        nxt.threshold_now = (half < FxTwo) ? FxTwo : half;
        nxt.window_now    = FxTwo;
      end
      default: nxt = cur;
    endcase
  end

  // Result fields from the updated state
  always_comb begin
    lim = (nxt.window_now < nxt.peer_window) ? nxt.window_now : nxt.peer_window;
    res.timeout_ms       = nxt.rto_value;
    res.send_limit       = lim[WinW-1:8];
    res.cong_window      = nxt.window_now;
    res.slow_start_limit = nxt.threshold_now;
  end

endmodule

// ----- hw/rtl/congestion_window_rto_estimator_top.sv -----
// Top level of the congestion window / RTO estimator: stream ports, state
// registers, configuration port and result register.
// Depends on cwre_pkg, cwre_in_stage and cwre_update.
//
// Usage:
//   Slave stream carries ack and timeout events; tuser holds the kind
//   (cmd) and the sample flag, tdata holds rtt_ms and receiver_window.
//   Master stream returns one result item per event: timeout, send limit,
//   congestion window and slow start threshold after that event.
//   An accepted event waits in the input register; when the result register is
//   free or draining, it writes the state and the result register and raises m_tvalid.
//   Throughput is one event per cycle unless the master stalls; the state
//   update is a single pass of adds, shifts and compares, so consecutive events
//   chain directly. A stalled master holds the result register; the input register
//   still takes one more item, after which s_tready drops until m_tready returns.
//   Reset clears both stages and loads the state: timeout 5000 ms, window
//   512 (2.0), threshold and receiver window 16384 (64.0), no samples.
//   Config writes (cfg_we) take effect at once; the user must do them while
//   idle, the block itself does not enforce it: initial_window loads the window,
//   window_cap loads cap, threshold and receiver window.
module congestion_window_rto_estimator_top import cwre_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [InDataW-1:0]   s_tdata,   // [15:0] rtt_ms, [39:16] receiver_window
  input  logic [InUserW-1:0]   s_tuser,   // [0] cmd, [1] sample_valid
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OutDataW-1:0]  m_tdata,   // [12:0] timeout_ms, [28:13] send_limit,
                                          // [52:29] cong_window, [76:53] slow_start_limit
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [WinW-1:0]      cfg_data
);

  item_t            s_item;
  item_t            item;
  logic             item_valid;
  logic             take;
  state_t           cur;
  state_t           nxt;
  result_t          res;
  result_t          out_res;
  logic [WinW-1:0]  window_cap;

  // Unpack the slave stream
  always_comb begin
    s_item.cmd             = cmd_t'(s_tuser[0]);
    s_item.sample_valid    = s_tuser[1];
    s_item.rtt_ms          = s_tdata[RttW-1:0];
    s_item.receiver_window = s_tdata[RttW+WinW-1:RttW];
  end

  cwre_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_item     (s_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  cwre_update u_upd (
    .item       (item),
    .cur        (cur),
    .window_cap (window_cap),
    .nxt        (nxt),
    .res        (res)
  );

  // Advance when the result register is free or draining
  assign take = item_valid && (!m_tvalid || m_tready);

  // State and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_cap           <= WindowCapRst;
      cur.have_sample      <= 1'b0;
      cur.scaled_mean      <= '0;
      cur.scaled_deviation <= '0;
      cur.rto_value        <= RtoMax;
      cur.window_now       <= InitWindowRst;
      cur.threshold_now    <= WindowCapRst;
      cur.peer_window      <= WindowCapRst;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_INITIAL_WINDOW: begin
          cur.window_now <= cfg_data;
        end
        REG_WINDOW_CAP: begin
          window_cap        <= cfg_data;
          cur.threshold_now <= cfg_data;
          cur.peer_window   <= cfg_data;
        end
        default: ;
      endcase
    end else if (take) begin
      cur <= nxt;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= item_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= res;
    end
  end

  // Pack the master stream
  assign m_tdata = {3'b000, out_res.slow_start_limit, out_res.cong_window,
                    out_res.send_limit, out_res.timeout_ms};

endmodule

// ----- bench/cwre_checker.sv -----
// Scoreboard for the congestion window / RTO estimator: watches the event, result and
// register-write ports, predicts every result and compares it field by field.
// Depends on cwre_pkg for field widths, event kinds and register indexes.
module cwre_checker import cwre_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [InDataW-1:0]   s_tdata,   // [15:0] rtt_ms, [39:16] receiver_window
  input  logic [InUserW-1:0]   s_tuser,   // [0] cmd, [1] sample_valid
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [OutDataW-1:0]  m_tdata,   // [12:0] timeout_ms, [28:13] send_limit,
                                          // [52:29] cong_window, [76:53] slow_start_limit
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [WinW-1:0]      cfg_data,
  output int unsigned          mismatches,
  output int unsigned          outstanding,
  output int unsigned          reports_seen
);

  localparam longint GuardMs = 10;

  // Shadow copy of the controller
  logic            have_rtt;
  longint          smean;      // 8 x mean rtt
  longint          sdev;       // 4 x mean deviation
  logic [RtoW-1:0] rto;
  logic [WinW-1:0] cwnd;
  logic [WinW-1:0] ssthresh;
  logic [WinW-1:0] rwin_held;
  logic [WinW-1:0] cap;

  result_t         window_reports[$];
  int unsigned     miss_count = 0;
  int unsigned     seen_count = 0;

  function automatic logic [RtoW-1:0] bound_timeout(input longint v);
    logic [RtoW-1:0] r;
    if (v > longint'(RtoMax)) begin
      r = RtoMax;
    end else if (v < longint'(RtoMin)) begin
      r = RtoMin;
    end else begin
      r = RtoW'(v);
    end
    return r;
  endfunction

  // Advance the shadow state by one event and return the report it produces
  function automatic result_t apply_event(input item_t ev);
    result_t         r;
    longint          err;
    longint          mag;
    longint          est;
    logic [WinW:0]   grown;
    logic [WinW-1:0] lim;
    if (ev.cmd == CMD_ACK) begin
      rwin_held = ev.receiver_window;
      if (ev.sample_valid) begin
        if (!have_rtt) begin
          // first sample seeds the estimator
          have_rtt = 1'b1;
          smean    = longint'(ev.rtt_ms) * 8;
          sdev     = 0;
          est      = longint'(ev.rtt_ms) * 4 + GuardMs;
        end else begin
          err   = longint'(ev.rtt_ms) - (smean >>> 3);
          mag   = (err < 0) ? -err : err;
          smean = smean + err;
          sdev  = sdev + mag - (sdev >>> 2);
          est   = (smean >>> 3) + sdev + GuardMs;
        end
        rto = bound_timeout(est);
        // slow start doubles, congestion avoidance adds one; cap after growth
        if (cwnd < ssthresh) begin
          grown = {cwnd, 1'b0};
        end else begin
          grown = {1'b0, cwnd} + (WinW+1)'(FxOne);
        end
        if (grown > {1'b0, cap}) begin
          grown = {1'b0, cap};
        end
        cwnd = grown[WinW-1:0];
      end
    end else begin
      // timeout: back off, halve into threshold, restart window at 2.0
      rto      = bound_timeout(longint'(rto) * 2);
      ssthresh = cwnd >> 1;
      if (ssthresh < FxTwo) begin
        ssthresh = FxTwo;
      end
      cwnd = FxTwo;
    end
    lim                = (cwnd < rwin_held) ? cwnd : rwin_held;
    r.timeout_ms       = rto;
    r.send_limit       = lim[WinW-1:8];
    r.cong_window      = cwnd;
    r.slow_start_limit = ssthresh;
    return r;
  endfunction

  function automatic void flag_error(input string what);
    miss_count++;
    if (miss_count <= 10) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endfunction

  always @(posedge clk) begin
    item_t   ev;
    result_t got;
    result_t want;
    if (rst) begin
      have_rtt  = 1'b0;
      smean     = 0;
      sdev      = 0;
      rto       = RtoMax;
      cap       = WindowCapRst;
      cwnd      = InitWindowRst;
      ssthresh  = WindowCapRst;
      rwin_held = WindowCapRst;
      window_reports.delete();
    end else begin
      // register writes reload the dependent state
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_INITIAL_WINDOW: begin
            cwnd     = cfg_data;
          end
          REG_WINDOW_CAP: begin
            cap       = cfg_data;
            ssthresh  = cfg_data;
            rwin_held = cfg_data;
          end
          default: ;
        endcase
      end

      // accepted event: predict its report
      if (s_tvalid && s_tready) begin
        ev.cmd             = cmd_t'(s_tuser[0]);
        ev.sample_valid    = s_tuser[1];
        ev.rtt_ms          = s_tdata[RttW-1:0];
        ev.receiver_window = s_tdata[RttW +: WinW];
        window_reports.push_back(apply_event(ev));
      end

      // accepted report: compare with the oldest prediction
      if (m_tvalid && m_tready) begin
        seen_count++;
        got.timeout_ms       = m_tdata[RtoW-1:0];
        got.send_limit       = m_tdata[RtoW +: LimW];
        got.cong_window      = m_tdata[RtoW+LimW +: WinW];
        got.slow_start_limit = m_tdata[RtoW+LimW+WinW +: WinW];
        if (window_reports.size() == 0) begin
          flag_error($sformatf("result with nothing pending, tdata 0x%0h", m_tdata));
        end else begin
          want = window_reports.pop_front();
          if (got.timeout_ms !== want.timeout_ms) begin
            flag_error($sformatf("timeout_ms expected %0d got %0d",
                                 want.timeout_ms, got.timeout_ms));
          end
          if (got.send_limit !== want.send_limit) begin
            flag_error($sformatf("send_limit expected %0d got %0d",
                                 want.send_limit, got.send_limit));
          end
          if (got.cong_window !== want.cong_window) begin
            flag_error($sformatf("cong_window expected 0x%0h got 0x%0h",
                                 want.cong_window, got.cong_window));
          end
          if (got.slow_start_limit !== want.slow_start_limit) begin
            flag_error($sformatf("slow_start_limit expected 0x%0h got 0x%0h",
                                 want.slow_start_limit, got.slow_start_limit));
          end
        end
      end
    end
    mismatches   <= miss_count;
    outstanding  <= window_reports.size();
    reports_seen <= seen_count;
  end

endmodule

// ----- bench/tb_top.sv -----
// Top of the estimator testbench: clock, reset, event stimulus, register settings,
// result-side back-pressure and the verdict.
// Depends on cwre_pkg, congestion_window_rto_estimator_top and cwre_checker.
module tb_top import cwre_pkg::*;;

  localparam int unsigned EventsPerSetting = 136;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata   = '0;   // [15:0] rtt_ms, [39:16] receiver_window
  logic [InUserW-1:0]  s_tuser   = '0;   // [0] cmd, [1] sample_valid
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [OutDataW-1:0] m_tdata;          // [12:0] timeout_ms, [28:13] send_limit,
                                         // [52:29] cong_window, [76:53] slow_start_limit
  logic                cfg_we    = 1'b0;
  logic [0:0]          cfg_index = '0;
  logic [WinW-1:0]     cfg_data  = '0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned reports_seen;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned n_sampled = 0;
  int unsigned n_bare    = 0;
  int unsigned n_timeout = 0;
  int unsigned n_setting = 1;

  congestion_window_rto_estimator_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cwre_checker window_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .reports_seen (reports_seen)
  );

  always #6 clk = ~clk;

  // result side back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // hard stop
  initial begin
    #(200_000 * 12);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic item_t mk_event(input cmd_t c, input logic sv,
                                     input logic [RttW-1:0] r, input logic [WinW-1:0] w);
    item_t ev;
    ev.cmd             = c;
    ev.sample_valid    = sv;
    ev.rtt_ms          = r;
    ev.receiver_window = w;
    return ev;
  endfunction

  // mostly acks with samples, some bare acks and timeouts
  function automatic item_t random_event();
    item_t       ev;
    int unsigned pick;
    pick               = $urandom_range(99);
    ev.cmd             = (pick < 15) ? CMD_TIMEOUT : CMD_ACK;
    ev.sample_valid    = (pick >= 30) ? 1'b1 : 1'($urandom_range(1));
    if (pick >= 15 && pick < 30) begin
      ev.sample_valid = 1'b0;
    end
    ev.rtt_ms          = ($urandom_range(99) < 75) ? RttW'($urandom_range(2000))
                                                   : RttW'($urandom_range(65535));
    ev.receiver_window = ($urandom_range(99) < 40) ? WinW'($urandom_range(20000))
                                                   : WinW'($urandom());
    return ev;
  endfunction

  // four back-pressure modes: none, sender idle, receiver stall, both
  function automatic void set_idling(input int unsigned mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 69; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 69; end
      default: begin idle_pct = 31; stall_pct = 31; end
    endcase
  endfunction

  task automatic send_event(input item_t ev);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {ev.sample_valid, ev.cmd};
    s_tdata  <= {ev.receiver_window, ev.rtt_ms};
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    if (ev.cmd == CMD_TIMEOUT) begin
      n_timeout++;
    end else if (ev.sample_valid) begin
      n_sampled++;
    end else begin
      n_bare++;
    end
  endtask

  // hold off until every predicted result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic load_windows(input logic [WinW-1:0] iw, input logic [WinW-1:0] cap_v);
    cfg_we    <= 1'b1;
    cfg_index <= REG_INITIAL_WINDOW;
    cfg_data  <= iw;
    @(posedge clk);
    cfg_index <= REG_WINDOW_CAP;
    cfg_data  <= cap_v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_setting++;
  endtask

  initial begin
    logic [WinW-1:0] iw_list  [7];
    logic [WinW-1:0] cap_list [7];

    // window settings: zero, all ones, doubling past 24 bits, window above cap, small, random, reset
    iw_list[0] = '0;           cap_list[0] = '0;
    iw_list[1] = 24'hFFFFFF;   cap_list[1] = 24'hFFFFFF;
    iw_list[2] = 24'h900000;   cap_list[2] = 24'hFFFFFF;
    iw_list[3] = 24'hFFFFFF;   cap_list[3] = FxTwo;
    iw_list[4] = FxOne;        cap_list[4] = 24'h00C800;
    iw_list[5] = WinW'($urandom_range(4096));
    cap_list[5] = WinW'($urandom_range(1024, 65536));
    iw_list[6] = InitWindowRst; cap_list[6] = WindowCapRst;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed events at reset settings
    send_event(mk_event(CMD_ACK, 1'b0, 16'd0, 24'h000000));
    send_event(mk_event(CMD_ACK, 1'b0, 16'hFFFF, 24'hFFFFFF));
    // first sample, large enough to hit the upper timeout bound
    send_event(mk_event(CMD_ACK, 1'b1, 16'hFFFF, 24'hFFFFFF));
    // zero samples pull the estimate down while the timeout stays at the upper bound
    repeat (6) send_event(mk_event(CMD_ACK, 1'b1, 16'd0, 24'hFFFFFF));
    // timeouts ignore the sample and window fields; backoff saturates
    send_event(mk_event(CMD_TIMEOUT, 1'b1, 16'd1234, 24'h000000));
    send_event(mk_event(CMD_TIMEOUT, 1'b0, 16'hFFFF, 24'hFFFFFF));
    repeat (3) send_event(mk_event(CMD_TIMEOUT, 1'b1, 16'd0, 24'h000100));
    // small receiver window, then additive growth in congestion avoidance
    send_event(mk_event(CMD_ACK, 1'b1, 16'd200, 24'h001000));
    repeat (6) send_event(mk_event(CMD_ACK, 1'b1, 16'd300, 24'hFFFFFF));
    send_event(mk_event(CMD_ACK, 1'b0, 16'd0, 24'h123456));
    send_event(mk_event(CMD_ACK, 1'b1, 16'd1, 24'hFFFFFF));
    wait_drained();

    // random events under each window setting
    for (int unsigned p = 0; p < 7; p++) begin
      load_windows(iw_list[p], cap_list[p]);
      for (int unsigned k = 0; k < EventsPerSetting; k++) begin
        set_idling(((p * EventsPerSetting + k) / 34) % 4);
        if (k == EventsPerSetting / 2) begin
          wait_drained();
        end
        send_event(random_event());
      end
      wait_drained();
      repeat (4) @(posedge clk);
    end

    stall_pct = 0;
    repeat (20) @(posedge clk);
    $display("Ran %0d sampled acks, %0d bare acks and %0d timeouts over %0d window settings,",
             n_sampled, n_bare, n_timeout, n_setting);
    $display("with idle and stall phases; %0d results compared.", reports_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
